// ===== hw/rtl/skyline_atlas_allocator_top_defines.svh =====
// Assertion macros for the allocator's checker file.
// Depends on nothing; include this file by its bare name.
`ifndef SKYLINE_ATLAS_ALLOCATOR_TOP_DEFINES_SVH
`define SKYLINE_ATLAS_ALLOCATOR_TOP_DEFINES_SVH

// Checks a property at every rising edge while reset is low.
`define SKYATL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checks a property at every rising edge, reset included.
`define SKYATL_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== hw/rtl/skyatl_pkg.sv =====
// Shared constants and types of the skyline atlas allocator.
// Depends on nothing.
package skyatl_pkg;
   localparam int NUM_PAGES   = 64;
   localparam int PAGE_WIDTH  = 128;
   localparam int PAGE_HEIGHT = 128;
   localparam int PAGE_BITS   = 6;
   localparam int COL_BITS    = 7;
   localparam int ADDR_BITS   = PAGE_BITS + COL_BITS;
   localparam int HGT_BITS    = 8;
   localparam int DEPTH       = NUM_PAGES * PAGE_WIDTH;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_PAGE, ST_RD, ST_CMP, ST_EVAL, ST_WR, ST_DONE
   } state_type;
endpackage

// ===== hw/rtl/skyatl_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module skyatl_ram #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== hw/rtl/skyline_atlas_allocator_top.sv =====
// Top level of the skyline atlas allocator: request sequencer around the column height RAM.
// Depends on skyatl_pkg and skyatl_ram.
//
// Each page holds one height per column in a single RAM that is read one column at a time,
// through ST_RD and then ST_CMP. An allocation tests every window of the page column by
// column, stopping a window at the first column that is not below the best height found so
// far; the request repeats that search for each page searched, then writes the raised columns
// in ST_WR. After reset, and for every clear word, the block sweeps all 8192 entries to zero,
// one a cycle, before it accepts another word.
module skyline_atlas_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rect_width[7:0], rect_height[15:8]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // page[5:0], pos_x[12:6], pos_y[19:13], zero[23:20]
   output logic        rsp_tuser,   // failed
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // pages_in_use
);
   import skyatl_pkg::*;

   state_type state_ff, state_in;
   logic [6:0] piu_ff, npages;
   logic [6:0] p_ff, p_in;
   logic [7:0] i_ff, i_in, j_ff, j_in, w_ff, w_in, h_ff, h_in;
   logic [7:0] top_ff, top_in, best_ff, best_in, top_n;
   logic [6:0] bx_ff, bx_in;
   logic found_ff, found_in, clr_ff, clr_in;
   logic [ADDR_BITS-1:0] sweep_ff, sweep_in;
   logic res_fail_ff, res_fail_in;
   logic [5:0] res_page_ff, res_page_in;
   logic [6:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in;
   logic we;
   logic [ADDR_BITS-1:0] waddr, raddr;
   logic [HGT_BITS-1:0] wdata, rdata;
   logic [8:0] sum, next_end;
   logic [7:0] col;
   logic [7:0] wcol;

   skyatl_ram #(.DEPTH(DEPTH), .WIDTH(HGT_BITS)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
   );

   assign npages = (piu_ff > 7'(NUM_PAGES)) ? 7'(NUM_PAGES) : piu_ff;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign sum = {1'b0, best_ff} + {1'b0, h_ff};
   assign next_end = {1'b0, i_ff} + 9'd1 + {1'b0, w_ff};
   assign col = i_ff + j_ff;
   assign wcol = {1'b0, bx_ff} + j_ff;
   assign raddr = {p_ff[PAGE_BITS-1:0], col[COL_BITS-1:0]};
   assign top_n = (rdata > top_ff) ? rdata : top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         piu_ff <= 7'(NUM_PAGES);
         sweep_ff <= '0;
         clr_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            piu_ff <= csr_data;
         end
         sweep_ff <= sweep_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      i_ff <= i_in;
      j_ff <= j_in;
      w_ff <= w_in;
      h_ff <= h_in;
      top_ff <= top_in;
      best_ff <= best_in;
      bx_ff <= bx_in;
      found_ff <= found_in;
      res_fail_ff <= res_fail_in;
      res_page_ff <= res_page_in;
      res_x_ff <= res_x_in;
      res_y_ff <= res_y_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in = state_ff;
      p_in = p_ff;
      i_in = i_ff;
      j_in = j_ff;
      w_in = w_ff;
      h_in = h_ff;
      top_in = top_ff;
      best_in = best_ff;
      bx_in = bx_ff;
      found_in = found_ff;
      clr_in = clr_ff;
      sweep_in = sweep_ff;
      res_fail_in = res_fail_ff;
      res_page_in = res_page_ff;
      res_x_in = res_x_ff;
      res_y_in = res_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      req_tready = 1'b0;
      we = 1'b0;
      waddr = {p_ff[PAGE_BITS-1:0], wcol[COL_BITS-1:0]};
      wdata = sum[HGT_BITS-1:0];
      unique case (state_ff)
         ST_INIT: begin
            we = 1'b1;
            waddr = sweep_ff;
            wdata = '0;
            sweep_in = sweep_ff + 1'b1;
            if (&sweep_ff) begin
               if (clr_ff) begin
                  res_fail_in = 1'b0;
                  res_page_in = '0;
                  res_x_in = '0;
                  res_y_in = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
               clr_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               w_in = req_tdata[7:0];
               h_in = req_tdata[15:8];
               p_in = '0;
               res_page_in = '0;
               res_x_in = '0;
               res_y_in = '0;
               if (req_tuser == FUNC_CLEAR) begin
                  sweep_in = '0;
                  clr_in = 1'b1;
                  state_in = ST_INIT;
               end else if (req_tdata[7:0] == 8'd0 || req_tdata[15:8] == 8'd0 ||
                            {1'b0, req_tdata[7:0]} > 9'(PAGE_WIDTH) || npages == 7'd0) begin
                  res_fail_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PAGE;
               end
            end
         end
         ST_PAGE: begin
            i_in = '0;
            j_in = '0;
            top_in = '0;
            best_in = 8'(PAGE_HEIGHT);
            found_in = 1'b0;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (rdata < best_ff && j_ff + 8'd1 != w_ff) begin
               j_in = j_ff + 8'd1;
               top_in = top_n;
               state_in = ST_RD;
            end else begin
               if (rdata < best_ff) begin
                  best_in = top_n;
                  bx_in = i_ff[COL_BITS-1:0];
                  found_in = 1'b1;
               end
               if (next_end > 9'(PAGE_WIDTH)) begin
                  state_in = ST_EVAL;
               end else begin
                  i_in = i_ff + 8'd1;
                  j_in = '0;
                  top_in = '0;
                  state_in = ST_RD;
               end
            end
         end
         ST_EVAL: begin
            if (found_ff && sum <= 9'(PAGE_HEIGHT)) begin
               j_in = '0;
               state_in = ST_WR;
            end else if (p_ff + 7'd1 == npages) begin
               res_fail_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               p_in = p_ff + 7'd1;
               state_in = ST_PAGE;
            end
         end
         ST_WR: begin
            we = 1'b1;
            j_in = j_ff + 8'd1;
            if (j_ff + 8'd1 == w_ff) begin
               res_fail_in = 1'b0;
               res_page_in = p_ff[PAGE_BITS-1:0];
               res_x_in = bx_ff;
               res_y_in = best_ff[COL_BITS-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {4'd0, res_y_ff, res_x_ff, res_page_ff};
               rsp_user_in = res_fail_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== hw/rtl/skyatl_checker.sv =====
// Port-level checker for the skyline atlas allocator, bound to the top level.
// Depends on skyline_atlas_allocator_top_defines.svh.
`include "skyline_atlas_allocator_top_defines.svh"

module skyatl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);
   `SKYATL_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `SKYATL_ASSERT(a_fail_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
   `SKYATL_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `SKYATL_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid && !req_tready)
endmodule

bind skyline_atlas_allocator_top skyatl_checker u_skyatl_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
